/* hdl/assert_macros.svh */
// Assertion macros used by the top level of the signature classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("Assertion failed.");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("Forbidden condition seen.");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

/* hdl/fsc_pkg.sv */
// Types, type codes and signature tables of the file signature classifier.
`timescale 1ns / 1ps

package fsc_pkg;

    localparam int NSIG    = 12;
    localparam int SIG_MAX = 12;
    localparam int SIG_MP4 = 6;

    typedef logic [NSIG-1:0] t_sig_vec;

    typedef enum logic [3:0] {
        TYPE_NONE = 4'd0,
        TYPE_PDF  = 4'd1,
        TYPE_PNG  = 4'd2,
        TYPE_JPEG = 4'd3,
        TYPE_GIF  = 4'd4,
        TYPE_WEBP = 4'd5,
        TYPE_MP4  = 4'd6,
        TYPE_MP3  = 4'd7,
        TYPE_ZIP  = 4'd8,
        TYPE_ELF  = 4'd9,
        TYPE_PE   = 4'd10,
        TYPE_JSON = 4'd11
    } t_type_code;

    typedef enum logic [1:0] {
        JSON_SKIP = 2'd0,
        JSON_OPEN = 2'd1,
        JSON_FAIL = 2'd2
    } t_json_phase;

    localparam logic [3:0] SIG_LEN [NSIG] = '{
        4'd5, 4'd8, 4'd3, 4'd6, 4'd6, 4'd12, 4'd12, 4'd3, 4'd2, 4'd4, 4'd4, 4'd2
    };

    localparam t_type_code SIG_CODE [NSIG] = '{
        TYPE_PDF, TYPE_PNG, TYPE_JPEG, TYPE_GIF, TYPE_GIF, TYPE_WEBP,
        TYPE_MP4, TYPE_MP3, TYPE_MP3, TYPE_ZIP, TYPE_ELF, TYPE_PE
    };

    localparam logic [7:0] SIG_VAL [NSIG][SIG_MAX] = '{
        '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A,
          8'h1A, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h57, 8'h45, 8'h42, 8'h50},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h66, 8'h74,
          8'h79, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h44, 8'h33, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h7F, 8'h45, 8'h4C, 8'h46, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [7:0] SIG_MASK [NSIG][SIG_MAX] = '{
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
          8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
          8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

endpackage

/* hdl/fsc_sig_match.sv */
// Per-signature byte compare at the current buffer offset.
`timescale 1ns / 1ps

module fsc_sig_match (
    input  logic [3:0]      i_pos,
    input  logic [7:0]      i_byte,
    output fsc_pkg::t_sig_vec o_fit
);

    // A signature whose length the offset has passed is not checked.
    always_comb begin
        for (int i = 0; i < fsc_pkg::NSIG; i++) begin
            o_fit[i] = 1'b1;
            if (i_pos < fsc_pkg::SIG_LEN[i]) begin
                o_fit[i] = ((i_byte & fsc_pkg::SIG_MASK[i][i_pos])
                            == fsc_pkg::SIG_VAL[i][i_pos]);
            end
        end
    end

endmodule

/* hdl/file_signature_classifier.sv */
// Top level of the file signature classifier: tracking state, priority pick, output register.
// Throughput: one byte transfer per cycle while the result side is not stalled.
// The type code is registered and appears on the result port in the cycle after the transfer of the
// byte that carries tlast; bytes without tlast produce no result.
// The signature compare, state update and priority pick form one combinational pass.
// Reset (synchronous, active low) clears the byte position, re-arms all signatures,
// and empties the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module file_signature_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // last_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [3:0] type_code, [7:4] zero
);

    logic [3:0]                r_byte_pos;
    logic [3:0]                n_byte_pos;
    fsc_pkg::t_sig_vec         r_sig_alive;
    fsc_pkg::t_sig_vec         n_sig_alive;
    logic                      r_box_hz;
    logic                      n_box_hz;
    logic                      r_box_ok;
    logic                      n_box_ok;
    fsc_pkg::t_json_phase      r_json_phase;
    fsc_pkg::t_json_phase      n_json_phase;
    logic                      r_out_valid;
    fsc_pkg::t_type_code       r_out_code;

    fsc_pkg::t_sig_vec         fit;
    fsc_pkg::t_sig_vec         alive_now;
    fsc_pkg::t_sig_vec         hit;
    logic [4:0]                count;
    logic                      box_ok_now;
    fsc_pkg::t_json_phase      json_now;
    fsc_pkg::t_type_code       code;
    logic                      s_fire;
    logic                      is_space;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_code};

    fsc_sig_match u_match (
        .i_pos  (r_byte_pos),
        .i_byte (i_s_tdata),
        .o_fit  (fit)
    );

    assign is_space = (i_s_tdata == 8'h20) || (i_s_tdata == 8'h09) ||
                      (i_s_tdata == 8'h0A) || (i_s_tdata == 8'h0D);

    always_comb begin
        alive_now  = r_sig_alive & fit;
        box_ok_now = r_box_ok;
        n_box_hz   = r_box_hz;
        if (r_byte_pos < 4'd3) begin
            if (i_s_tdata != 8'h00) begin
                n_box_hz = 1'b0;
            end
        end else if (r_byte_pos == 4'd3) begin
            box_ok_now = !r_box_hz || (i_s_tdata >= 8'd8);
        end

        unique case (r_json_phase)
            fsc_pkg::JSON_SKIP: begin
                if ((i_s_tdata == 8'h7B) || (i_s_tdata == 8'h5B)) begin
                    json_now = fsc_pkg::JSON_OPEN;
                end else if (!is_space) begin
                    json_now = fsc_pkg::JSON_FAIL;
                end else begin
                    json_now = fsc_pkg::JSON_SKIP;
                end
            end
            fsc_pkg::JSON_OPEN: json_now = fsc_pkg::JSON_OPEN;
            default:            json_now = fsc_pkg::JSON_FAIL;
        endcase
    end

    always_comb begin
        count = {1'b0, r_byte_pos} + 5'd1;
        for (int i = 0; i < fsc_pkg::NSIG; i++) begin
            hit[i] = alive_now[i] && (count >= {1'b0, fsc_pkg::SIG_LEN[i]}) &&
                     ((i != fsc_pkg::SIG_MP4) || box_ok_now);
        end
        code = fsc_pkg::TYPE_NONE;
        for (int i = fsc_pkg::NSIG - 1; i >= 0; i--) begin
            if (hit[i]) begin
                code = fsc_pkg::SIG_CODE[i];
            end
        end
        if ((code == fsc_pkg::TYPE_NONE) && (json_now == fsc_pkg::JSON_OPEN)) begin
            code = fsc_pkg::TYPE_JSON;
        end
    end

    // The final byte of a buffer returns all tracking state to its start values.
    always_comb begin
        n_byte_pos   = r_byte_pos;
        n_sig_alive  = r_sig_alive;
        n_box_ok     = r_box_ok;
        n_json_phase = r_json_phase;
        if (s_fire) begin
            if (i_s_tlast) begin
                n_byte_pos   = 4'd0;
                n_sig_alive  = '1;
                n_box_ok     = 1'b0;
                n_json_phase = fsc_pkg::JSON_SKIP;
            end else begin
                n_byte_pos   = (r_byte_pos == 4'd15) ? r_byte_pos : r_byte_pos + 4'd1;
                n_sig_alive  = alive_now;
                n_box_ok     = box_ok_now;
                n_json_phase = json_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos   <= 4'd0;
            r_sig_alive  <= '1;
            r_box_hz     <= 1'b1;
            r_box_ok     <= 1'b0;
            r_json_phase <= fsc_pkg::JSON_SKIP;
        end else begin
            r_byte_pos   <= n_byte_pos;
            r_sig_alive  <= n_sig_alive;
            r_box_ok     <= n_box_ok;
            r_json_phase <= n_json_phase;
            if (s_fire) begin
                r_box_hz <= i_s_tlast ? 1'b1 : n_box_hz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire && i_s_tlast) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && i_s_tlast) begin
            r_out_code <= code;
        end
    end

    `ASSERT_CLK(a_last_gives_result, i_clk, i_rst_n, s_fire && i_s_tlast |=> r_out_valid)
    `ASSERT_CLK(a_last_rewinds, i_clk, i_rst_n, s_fire && i_s_tlast |=> r_byte_pos == 4'd0)
    `ASSERT_CLK(a_mid_advances, i_clk, i_rst_n, s_fire && !i_s_tlast |=> r_byte_pos != 4'd0)
    `ASSERT_CLK(a_start_all_alive, i_clk, i_rst_n, r_byte_pos == 4'd0 |-> (&r_sig_alive))
    `ASSERT_NEVER(a_json_needs_byte, i_clk, i_rst_n,
        (r_byte_pos == 4'd0) && (r_json_phase != fsc_pkg::JSON_SKIP))

endmodule
